// ----- sv/byte_credit_inorder_job_window_assert.svh -----
// ----------------------------------------------------------------------------
// Job window assertion macros
// Clocked assertion shorthands used by the job window RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_CREDIT_INORDER_JOB_WINDOW_ASSERT_SVH
`define BYTE_CREDIT_INORDER_JOB_WINDOW_ASSERT_SVH

// checked only out of reset
`define BCIW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define BCIW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/bciw_pkg.sv -----
// ----------------------------------------------------------------------------
// Job window package
// Opcodes, status codes and the memory control word.
// ----------------------------------------------------------------------------
package bciw_pkg;

  localparam int COST_W = 48;

  localparam logic [1:0] OP_ENQ   = 2'd0;
  localparam logic [1:0] OP_ISSUE = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;
  localparam logic [1:0] OP_POP   = 2'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_NONE = 3'd2;
  localparam logic [2:0] ST_REJ  = 3'd3;
  localparam logic [2:0] ST_INV  = 3'd4;

  localparam logic CFG_WORKERS = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef struct packed {
    logic cost_we;
    logic done_we;
    logic done_wbit;
  } mem_ctl_t;

endpackage

// ----- sv/bciw_mem.sv -----
// ----------------------------------------------------------------------------
// Job window tables
// Cost and done-flag memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module bciw_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  bciw_pkg::mem_ctl_t        ctl,
  input  logic [AW-1:0]             cost_waddr,
  input  logic [bciw_pkg::COST_W-1:0] cost_wdata,
  input  logic [AW-1:0]             done_waddr,
  input  logic [AW-1:0]             cost_raddr,
  input  logic [AW-1:0]             done_raddr,
  output logic [bciw_pkg::COST_W-1:0] cost_rdata,
  output logic                      done_rdata
);
  import bciw_pkg::*;

  logic [COST_W-1:0] cost_mem [DEPTH];
  logic              done_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    cost_rdata <= cost_mem[cost_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.done_we) begin
      done_mem[done_waddr] <= ctl.done_wbit;
    end
    done_rdata <= done_mem[done_raddr];
  end

endmodule

// ----- sv/byte_credit_inorder_job_window.sv -----
// ----------------------------------------------------------------------------
// Byte credit in-order job window
// Each word is accepted in idle, then handled in the execute state after the table read.
// Result strobes in the cycle after execute; a new word is taken while it shows.
// Busy is held during execute, so a new word is taken only once the last has executed.
// Sync reset clears pointers, totals, peaks and done tracking; tables unset.
// ----------------------------------------------------------------------------
module byte_credit_inorder_job_window #(
  parameter int JOB_DEPTH   = 64,
  parameter int MAX_WORKERS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [47:0] in_job_cost,
  input  logic [5:0]  in_job_slot,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_granted_slot,
  output logic [47:0] out_bytes_reserved,
  output logic [6:0]  out_in_flight,
  output logic        out_front_ready,
  output logic [47:0] out_peak_bytes,
  output logic [6:0]  out_peak_in_flight,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata
);
  import bciw_pkg::*;

  localparam int AW   = $clog2(JOB_DEPTH);
  localparam int PW   = $clog2(JOB_DEPTH + 1);
  localparam int EW   = (PW > 7) ? PW : 7;
  localparam int CMPW = (PW > 6) ? PW : 6;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  logic [3:0]        worker_r;
  logic [COST_W-1:0] limit_r;

  logic [1:0]        op_r;
  logic [COST_W-1:0] cost_r;
  logic [5:0]        slot_r;

  logic [PW-1:0]     loaded_r, loaded_nxt;
  logic [PW-1:0]     issue_r, issue_nxt;
  logic [PW-1:0]     retire_r, retire_nxt;
  logic [COST_W-1:0] reserved_r, reserved_nxt;
  logic [COST_W-1:0] peak_r, peak_nxt;
  logic [PW-1:0]     peak_out_r, peak_out_nxt;
  logic              front_done_r, front_done_nxt;

  logic              out_valid_r;
  logic [2:0]        status_r, status_nxt;
  logic [5:0]        granted_r;
  logic [AW-1:0]     granted_nxt;
  logic [COST_W-1:0] out_res_r;
  logic [6:0]        out_fly_r;
  logic              out_front_r;
  logic [COST_W-1:0] out_peak_r;
  logic [6:0]        out_peak_fly_r;

  mem_ctl_t          mctl;
  logic [AW-1:0]     done_waddr;
  logic [AW-1:0]     cost_raddr;
  logic [AW-1:0]     done_raddr;
  logic [COST_W-1:0] cost_rdata;
  logic              done_rdata;

  logic              accept;
  logic [PW-1:0]     retire_inc;
  logic [15:0]       slot_wide;
  logic [CMPW-1:0]   slot_cmp;
  logic [EW-1:0]     wc, eff;
  logic [EW:0]       window, outst;
  logic [COST_W:0]   sum_res;
  logic              fits;
  logic [PW-1:0]     fly_nxt;
  logic [15:0]       fly_wide, peak_fly_wide, granted_wide;

  assign busy   = (state_r == S_EXEC) || !rst_n;
  assign accept = start && !busy;

  assign retire_inc = retire_r + PW'(1);
  assign slot_wide  = 16'(slot_r);
  assign slot_cmp   = CMPW'(slot_r);

  assign cost_raddr = (in_opcode == OP_ISSUE) ? issue_r[AW-1:0] : retire_r[AW-1:0];
  assign done_raddr = retire_inc[AW-1:0];
  assign done_waddr = (op_r == OP_ENQ) ? loaded_r[AW-1:0] : slot_wide[AW-1:0];

  bciw_mem #(.DEPTH(JOB_DEPTH), .AW(AW)) u_mem (
    .clk        (clk),
    .ctl        (mctl),
    .cost_waddr (loaded_r[AW-1:0]),
    .cost_wdata (cost_r),
    .done_waddr (done_waddr),
    .cost_raddr (cost_raddr),
    .done_raddr (done_raddr),
    .cost_rdata (cost_rdata),
    .done_rdata (done_rdata)
  );

  always_comb begin
    wc = EW'(worker_r);
    if (wc == '0) begin
      wc = EW'(1);
    end
    if (wc > EW'(MAX_WORKERS)) begin
      wc = EW'(MAX_WORKERS);
    end
    eff = (wc > EW'(loaded_r)) ? EW'(loaded_r) : wc;
  end

  assign window  = {eff, 1'b0};
  assign outst   = (EW + 1)'(issue_r - retire_r);
  assign sum_res = {1'b0, reserved_r} + {1'b0, cost_rdata};
  assign fits    = (cost_rdata == '0) || (sum_res <= {1'b0, limit_r});

  always_comb begin
    state_nxt      = state_r;
    loaded_nxt     = loaded_r;
    issue_nxt      = issue_r;
    retire_nxt     = retire_r;
    reserved_nxt   = reserved_r;
    peak_nxt       = peak_r;
    peak_out_nxt   = peak_out_r;
    front_done_nxt = front_done_r;
    status_nxt     = ST_OK;
    granted_nxt    = '0;
    mctl           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_ENQ: begin
            if (cost_r > limit_r || loaded_r == PW'(JOB_DEPTH)) begin
              status_nxt = ST_REJ;
            end else begin
              mctl.cost_we  = 1'b1;
              mctl.done_we  = 1'b1;
              mctl.done_wbit = 1'b0;
              granted_nxt   = loaded_r[AW-1:0];
              loaded_nxt    = loaded_r + PW'(1);
              if (retire_r == loaded_r) begin
                front_done_nxt = 1'b0;
              end
            end
          end
          OP_ISSUE: begin
            if (issue_r >= loaded_r) begin
              status_nxt = ST_NONE;
            end else if (outst < window && fits) begin
              granted_nxt  = issue_r[AW-1:0];
              issue_nxt    = issue_r + PW'(1);
              reserved_nxt = sum_res[COST_W-1:0];
              if (sum_res[COST_W-1:0] > peak_r) begin
                peak_nxt = sum_res[COST_W-1:0];
              end
              if (issue_nxt - retire_r > peak_out_r) begin
                peak_out_nxt = issue_nxt - retire_r;
              end
            end else begin
              status_nxt = ST_WAIT;
            end
          end
          OP_DONE: begin
            if (slot_cmp < CMPW'(retire_r) || slot_cmp >= CMPW'(issue_r)) begin
              status_nxt = ST_INV;
            end else begin
              mctl.done_we   = 1'b1;
              mctl.done_wbit = 1'b1;
              granted_nxt    = slot_wide[AW-1:0];
              if (slot_cmp == CMPW'(retire_r)) begin
                front_done_nxt = 1'b1;
              end
            end
          end
          OP_POP: begin
            if (retire_r >= loaded_r || !front_done_r) begin
              status_nxt = ST_INV;
            end else begin
              reserved_nxt   = (reserved_r >= cost_rdata) ? reserved_r - cost_rdata : '0;
              granted_nxt    = retire_r[AW-1:0];
              retire_nxt     = retire_inc;
              front_done_nxt = done_rdata;
            end
          end
          default: begin
            status_nxt = ST_INV;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign fly_nxt       = issue_nxt - retire_nxt;
  assign fly_wide      = 16'(fly_nxt);
  assign peak_fly_wide = 16'(peak_out_nxt);
  assign granted_wide  = 16'(granted_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      worker_r     <= 4'd1;
      limit_r      <= 48'd1073741824;
      loaded_r     <= '0;
      issue_r      <= '0;
      retire_r     <= '0;
      reserved_r   <= '0;
      peak_r       <= '0;
      peak_out_r   <= '0;
      front_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_r     <= loaded_nxt;
      issue_r      <= issue_nxt;
      retire_r     <= retire_nxt;
      reserved_r   <= reserved_nxt;
      peak_r       <= peak_nxt;
      peak_out_r   <= peak_out_nxt;
      front_done_r <= front_done_nxt;
      out_valid_r  <= (state_r == S_EXEC);
      if (cfg_we) begin
        if (cfg_index == CFG_WORKERS) begin
          worker_r <= cfg_wdata[3:0];
        end else begin
          limit_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      cost_r <= in_job_cost;
      slot_r <= in_job_slot;
    end
    if (state_r == S_EXEC) begin
      status_r       <= status_nxt;
      granted_r      <= granted_wide[5:0];
      out_res_r      <= reserved_nxt;
      out_fly_r      <= fly_wide[6:0];
      out_front_r    <= (retire_nxt < loaded_nxt) && front_done_nxt;
      out_peak_r     <= peak_nxt;
      out_peak_fly_r <= peak_fly_wide[6:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_granted_slot   = granted_r;
  assign out_bytes_reserved = out_res_r;
  assign out_in_flight      = out_fly_r;
  assign out_front_ready    = out_front_r;
  assign out_peak_bytes     = out_peak_r;
  assign out_peak_in_flight = out_peak_fly_r;

`include "byte_credit_inorder_job_window_assert.svh"

  `BCIW_ASSERT(a_ptr_order, (retire_r <= issue_r) && (issue_r <= loaded_r), "pointer order broken")
  `BCIW_ASSERT(a_exec_strobe, (state_r == S_EXEC) |=> out_valid, "execute gave no result")
  `BCIW_ASSERT(a_idle_hold, !busy |=> $stable(reserved_r) && $stable(retire_r), "state moved while idle")
  `BCIW_ASSERT(a_peak_fly, peak_out_r >= issue_r - retire_r, "peak outstanding below current")
  `BCIW_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid && !front_done_r, "reset left a result")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Job window testbench
// Sends enqueue, issue, complete and pop words in random bursts and predicts
// every result word from a local model of the job table and the byte budget.
// Results are checked in order and field by field; the worker count and the
// byte limit are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bciw_pkg::*;

  localparam int unsigned JOBS = 64;
  localparam int unsigned WORKER_CAP = 8;
  localparam int unsigned WORKER_FLOOR = 1;
  localparam logic [47:0] COST_MAX = '1;
  localparam logic [47:0] LIMIT_AT_RESET = 48'd1073741824;

  typedef struct {
    logic [1:0]  op;
    logic [47:0] cost;
    logic [5:0]  slot;
  } job_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [47:0] bytes;
    logic [6:0]  flight;
    logic        front;
    logic [47:0] peak_bytes;
    logic [6:0]  peak_flight;
  } window_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = OP_ENQ;
  logic [47:0] in_job_cost = '0;
  logic [5:0]  in_job_slot = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_granted_slot;
  logic [47:0] out_bytes_reserved;
  logic [6:0]  out_in_flight;
  logic        out_front_ready;
  logic [47:0] out_peak_bytes;
  logic [6:0]  out_peak_in_flight;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_WORKERS;
  logic [47:0] cfg_wdata = '0;

  byte_credit_inorder_job_window dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_job_cost        (in_job_cost),
    .in_job_slot        (in_job_slot),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_slot   (out_granted_slot),
    .out_bytes_reserved (out_bytes_reserved),
    .out_in_flight      (out_in_flight),
    .out_front_ready    (out_front_ready),
    .out_peak_bytes     (out_peak_bytes),
    .out_peak_in_flight (out_peak_in_flight),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #2 clk = ~clk;

  // local copy of the job table and budget
  logic [47:0] cost_mem [JOBS];
  bit          done_mem [JOBS];
  int unsigned n_loaded = 0;
  int unsigned issue_ix = 0;
  int unsigned retire_ix = 0;
  logic [47:0] held_bytes = '0;
  logic [47:0] top_bytes = '0;
  int unsigned top_jobs = 0;
  logic [3:0]  workers_cfg = 4'd1;
  logic [47:0] limit_cfg = LIMIT_AT_RESET;

  job_cmd_t       pending_cmds [$];
  window_result_t awaited_results [$];
  int unsigned    fail_cnt = 0;
  logic           took = 1'b0;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;

  function automatic window_result_t step_window(job_cmd_t c);
    window_result_t r;
    logic [47:0] room;
    logic [47:0] jc;
    int unsigned eff;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_ENQ: begin
        if (c.cost > limit_cfg || n_loaded >= JOBS) begin
          r.status = ST_REJ;
        end else begin
          cost_mem[n_loaded] = c.cost;
          done_mem[n_loaded] = 1'b0;
          r.slot = 6'(n_loaded);
          n_loaded++;
        end
      end
      OP_ISSUE: begin
        if (issue_ix >= n_loaded) begin
          r.status = ST_NONE;
        end else begin
          eff = workers_cfg;
          if (eff < WORKER_FLOOR) eff = WORKER_FLOOR;
          if (eff > WORKER_CAP) eff = WORKER_CAP;
          if (eff > n_loaded) eff = n_loaded;
          room = (limit_cfg > held_bytes) ? limit_cfg - held_bytes : '0;
          jc = cost_mem[issue_ix];
          if ((issue_ix - retire_ix) < 2 * eff && jc <= room) begin
            r.slot = 6'(issue_ix);
            issue_ix++;
            held_bytes = held_bytes + jc;
            if (held_bytes > top_bytes) top_bytes = held_bytes;
            if (issue_ix - retire_ix > top_jobs) top_jobs = issue_ix - retire_ix;
          end else begin
            r.status = ST_WAIT;
          end
        end
      end
      OP_DONE: begin
        if (c.slot < retire_ix || c.slot >= issue_ix) begin
          r.status = ST_INV;
        end else begin
          done_mem[c.slot] = 1'b1;
          r.slot = c.slot;
        end
      end
      default: begin
        if (retire_ix >= n_loaded || !done_mem[retire_ix]) begin
          r.status = ST_INV;
        end else begin
          jc = cost_mem[retire_ix];
          held_bytes = (held_bytes >= jc) ? held_bytes - jc : '0;
          r.slot = 6'(retire_ix);
          retire_ix++;
        end
      end
    endcase
    r.bytes = held_bytes;
    r.flight = 7'(issue_ix - retire_ix);
    r.front = (retire_ix < n_loaded) && done_mem[retire_ix];
    r.peak_bytes = top_bytes;
    r.peak_flight = 7'(top_jobs);
    return r;
  endfunction

  // driver: bursts of words with random gaps in between
  always @(negedge clk) begin
    if (took) begin
      void'(pending_cmds.pop_front());
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      end
    end
    if (gap_left == 0 && pending_cmds.size() != 0) begin
      start <= 1'b1;
      in_opcode <= pending_cmds[0].op;
      in_job_cost <= pending_cmds[0].cost;
      in_job_slot <= pending_cmds[0].slot;
    end else begin
      start <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  // monitor: predict on accept, check each result word in order
  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    job_cmd_t       c;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WORKERS) workers_cfg = cfg_wdata[3:0];
        else limit_cfg = cfg_wdata;
      end
      if (out_valid) begin
        got = {out_status, out_granted_slot, out_bytes_reserved, out_in_flight,
               out_front_ready, out_peak_bytes, out_peak_in_flight};
        if (awaited_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result word: status %0d slot %0d", out_status,
                     out_granted_slot);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"mismatch (exp/act): status %0d/%0d slot %0d/%0d ",
                        "bytes %0h/%0h flight %0d/%0d front %0b/%0b ",
                        "peak_bytes %0h/%0h peak_flight %0d/%0d"},
                       want.status, got.status, want.slot, got.slot,
                       want.bytes, got.bytes, want.flight, got.flight,
                       want.front, got.front, want.peak_bytes, got.peak_bytes,
                       want.peak_flight, got.peak_flight);
          end
        end
      end
      if (start && !busy) begin
        c.op = in_opcode;
        c.cost = in_job_cost;
        c.slot = in_job_slot;
        awaited_results.insert(awaited_results.size(), step_window(c));
      end
      took <= start && !busy;
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] workers_word(logic [3:0] w);
    return {44'(rand48()), w};
  endfunction

  task automatic put(logic [1:0] op, logic [47:0] cost, logic [5:0] slot);
    job_cmd_t c;
    c.op = op;
    c.cost = cost;
    c.slot = slot;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || awaited_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_cfg(logic idx, logic [47:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mixed traffic: enqueue/issue heavy first, complete/pop heavy later
  task automatic run_mix(int unsigned n_cmds, int unsigned enq_quota);
    int unsigned enq_left;
    int unsigned lo;
    int unsigned hi;
    int unsigned issued_gen;
    int unsigned pick;
    logic [63:0] span;
    job_cmd_t    c;
    enq_left = enq_quota;
    lo = (retire_ix > JOBS - 1) ? JOBS - 1 : retire_ix;
    issued_gen = 0;
    for (int unsigned k = 0; k < n_cmds; k++) begin
      c.cost = rand48();
      c.slot = 6'($urandom());
      pick = $urandom_range(0, 99);
      if (k < n_cmds / 2)
        c.op = (pick < 30) ? OP_ENQ : (pick < 65) ? OP_ISSUE : (pick < 85) ? OP_DONE : OP_POP;
      else
        c.op = (pick < 5) ? OP_ENQ : (pick < 30) ? OP_ISSUE : (pick < 70) ? OP_DONE : OP_POP;
      if (c.op == OP_ENQ) begin
        if (enq_left > 0) begin
          enq_left--;
          pick = $urandom_range(0, 7);
          span = {16'd0, limit_cfg >> 2} + 64'd1;
          if (pick == 0) c.cost = '0;
          else if (pick == 1) c.cost = limit_cfg;
          else c.cost = 48'({16'd0, rand48()} % span);
        end else if (limit_cfg != COST_MAX) begin
          span = {16'd0, COST_MAX - limit_cfg};
          c.cost = limit_cfg + 48'd1 + 48'({16'd0, rand48()} % span);
        end else begin
          c.op = OP_ISSUE;
        end
      end
      if (c.op == OP_ISSUE) issued_gen++;
      if (c.op == OP_DONE && $urandom_range(0, 6) != 0) begin
        hi = issue_ix + issued_gen;
        if (hi > JOBS - 1) hi = JOBS - 1;
        c.slot = 6'($urandom_range(lo, hi));
      end
      pending_cmds.insert(pending_cmds.size(), c);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty table, oversize costs, window and zero-cost jobs, repeated complete
    put(OP_POP, rand48(), 6'd0);
    put(OP_ISSUE, '0, 6'd0);
    put(OP_DONE, '0, 6'd63);
    put(OP_ENQ, LIMIT_AT_RESET + 48'd1, 6'd0);
    put(OP_ENQ, COST_MAX, 6'd63);
    put(OP_ENQ, LIMIT_AT_RESET, 6'd0);
    put(OP_ENQ, '0, 6'd0);
    put(OP_ENQ, 48'd60, 6'd0);
    put(OP_ENQ, '0, 6'd0);
    put(OP_ENQ, 48'd50, 6'd0);
    put(OP_ISSUE, '0, 6'd0);
    put(OP_ISSUE, '0, 6'd0);
    put(OP_ISSUE, '0, 6'd0);
    put(OP_DONE, '0, 6'd2);
    put(OP_POP, '0, 6'd0);
    put(OP_DONE, '0, 6'd1);
    put(OP_DONE, '0, 6'd0);
    put(OP_DONE, '0, 6'd0);
    put(OP_POP, '0, 6'd0);
    put(OP_POP, '0, 6'd0);
    put(OP_POP, '0, 6'd0);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd4));
    set_cfg(CFG_LIMIT, 48'd100);
    put(OP_ISSUE, '0, 6'd0);
    wait_idle();
    // limit now below the reserved total: only zero-cost jobs go out
    set_cfg(CFG_LIMIT, 48'd10);
    put(OP_ISSUE, '0, 6'd0);
    put(OP_ISSUE, '0, 6'd0);
    put(OP_DONE, '0, 6'd2);
    put(OP_POP, '0, 6'd0);

    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd2));
    set_cfg(CFG_LIMIT, LIMIT_AT_RESET);
    run_mix(60, 6);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd15));
    set_cfg(CFG_LIMIT, COST_MAX);
    run_mix(80, 14);
    wait_idle();
    set_cfg(CFG_LIMIT, '0);
    run_mix(50, 3);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd0));
    set_cfg(CFG_LIMIT, 48'd1000000);
    run_mix(80, 6);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd8));
    set_cfg(CFG_LIMIT, COST_MAX);
    run_mix(150, 10);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd3));
    set_cfg(CFG_LIMIT, rand48());
    run_mix(80, 5);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd1));
    set_cfg(CFG_LIMIT, 48'd4096);
    run_mix(80, 5);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd5));
    set_cfg(CFG_LIMIT, 48'd1 << 40);
    run_mix(80, 5);
    wait_idle();
    // fill the table to the end, then keep knocking on it
    set_cfg(CFG_WORKERS, workers_word(4'd8));
    set_cfg(CFG_LIMIT, COST_MAX);
    run_mix(120, JOBS);
    wait_idle();
    set_cfg(CFG_WORKERS, workers_word(4'd15));
    run_mix(100, JOBS);

    wait_idle();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
